FILE: rtl/core/ssnq_pkg.sv
// Shared types and constants of the sensor scale note quantiser.
// Scale tables, queue entry and configuration structs; no dependencies.
package ssnq_pkg;

  localparam int DIST_W  = 16;
  localparam int SCALE_W = 4;
  localparam int OCT_W   = 4;
  localparam int AMP_W   = 16;
  localparam int NOTE_W  = 8;
  localparam int ID_W    = 4;
  localparam int CFG_W   = 4;
  localparam int CIDX_W  = 2;

  // constant divider: numerator below 2^33, quotient below 2^17,
  // divisor (twice the detect range) below 2^17
  localparam int NUM_W = 34;
  localparam int QUO_W = 17;
  localparam int DIV_W = 17;
  localparam int MUL_W = 18;

  localparam int SCALE_COUNT = 11;
  localparam int SCALE_STEPS = 12;

  localparam logic [SCALE_W-1:0] SCALE_MAX   = 4'd10;
  localparam logic [OCT_W-1:0]   OCTAVE_MAX  = 4'd8;
  localparam logic [NOTE_W-1:0]  SEMIS       = 8'd12;
  localparam logic [NOTE_W-1:0]  NOTE_SHIFT  = 8'd6;
  localparam logic [DIV_W-1:0]   AMP_NUM_MUL = 17'd131070;  // 2 * 65535

  // sensor roles
  localparam int SENS_NOTE_B = 0;
  localparam int SENS_AMP_B  = 3;
  localparam int SENS_AMP_A  = 4;
  localparam int SENS_DET_X  = 5;
  localparam int SENS_NOTE_A = 6;
  localparam int SENS_DET_Y  = 7;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [CIDX_W-1:0] {
    CFG_BASE_OCTAVE = 2'd0,
    CFG_SCALE_BOTH  = 2'd1,
    CFG_SCALE_ONE   = 2'd2,
    CFG_SCALE_NONE  = 2'd3
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] RST_BASE_OCTAVE = 4'd4;
  localparam logic [CFG_W-1:0] RST_SCALE_BOTH  = 4'd1;
  localparam logic [CFG_W-1:0] RST_SCALE_ONE   = 4'd9;
  localparam logic [CFG_W-1:0] RST_SCALE_NONE  = 4'd0;

  typedef struct packed {
    logic [CFG_W-1:0] base_octave;
    logic [CFG_W-1:0] scale_both;
    logic [CFG_W-1:0] scale_one;
    logic [CFG_W-1:0] scale_none;
  } cfg_t;

  // classified item: saturated scale and inverted, clamped distances
  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [DIST_W-1:0]  inv_amp_a;
    logic [DIST_W-1:0]  inv_note_a;
    logic [DIST_W-1:0]  inv_amp_b;
    logic [DIST_W-1:0]  inv_note_b;
  } entry_t;

  localparam logic [3:0] SCALE_TAB [SCALE_COUNT][SCALE_STEPS] = '{
    '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd1, 4'd3, 4'd5, 4'd6, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd4, 4'd7, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd3, 4'd5, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd3, 4'd5, 4'd6, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11}
  };

  localparam logic [3:0] SCALE_LEN [SCALE_COUNT] = '{
    4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd5, 4'd5, 4'd6, 4'd12
  };

endpackage

FILE: rtl/core/sensor_scale_note_quantizer.sv
// Sensor scale note quantiser, top level: configuration registers, front end,
// queue and back end. Depends on ssnq_pkg, ssnq_front, ssnq_queue, ssnq_back.
//
// Usage
// - Input channel (in_valid / in_stall): one distance reading per transfer,
//   tagged with its sensor number. Each transfer writes the reading into the
//   distance store and causes exactly one result transfer.
// - Result channel (out_valid / out_stall): scale index, two amplitudes and
//   two notes computed from the store as it stands after that reading.
// - Configuration (cfg_we / cfg_index / cfg_wdata): octave and three scale
//   choices; write only while no transfer is in flight.
// - Path: an input transfer passes the queue, numerator stage, three divider
//   stages and result register before its result is offered.
// - Throughput: one transfer per cycle sustained while out_stall stays low; the
//   divider lanes are fully pipelined with fixed-divisor reciprocal multiplies.
// - Stall: a stalled result freezes the back-end pipe; the front keeps taking
//   transfers until the 4-entry queue fills, then raises in_stall.
// - Reset (synchronous, rst_n low): store entries to the detect range,
//   registers to their defaults, queue and pipe empty. No clearing pass.
module sensor_scale_note_quantizer
  import ssnq_pkg::*;
#(
  parameter int SENSOR_COUNT = 16,
  parameter int DETECT_RANGE = 200
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CIDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ID_W-1:0]          in_sensor_id,
  input  logic [DIST_W-1:0]        in_distance,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [SCALE_W-1:0]       out_scale_index,
  output logic [AMP_W-1:0]         out_amp_a,
  output logic signed [NOTE_W-1:0] out_note_a,
  output logic [AMP_W-1:0]         out_amp_b,
  output logic signed [NOTE_W-1:0] out_note_b
);

  cfg_t   cfg_r, cfg_nxt;
  logic   q_push, q_pop, q_full, q_empty;
  entry_t q_in, q_head;

  // configuration register file
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BASE_OCTAVE: cfg_nxt.base_octave = cfg_wdata;
        CFG_SCALE_BOTH:  cfg_nxt.scale_both  = cfg_wdata;
        CFG_SCALE_ONE:   cfg_nxt.scale_one   = cfg_wdata;
        CFG_SCALE_NONE:  cfg_nxt.scale_none  = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_octave <= RST_BASE_OCTAVE;
      cfg_r.scale_both  <= RST_SCALE_BOTH;
      cfg_r.scale_one   <= RST_SCALE_ONE;
      cfg_r.scale_none  <= RST_SCALE_NONE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: store update and scale classification
  ssnq_front #(
    .SENSOR_COUNT(SENSOR_COUNT),
    .DETECT_RANGE(DETECT_RANGE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_sensor_id(in_sensor_id),
    .in_distance (in_distance),
    .in_stall    (in_stall),
    .cfg         (cfg_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_in)
  );

  // decoupling queue
  ssnq_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_in),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: arithmetic pipe and result register
  ssnq_back #(
    .DETECT_RANGE(DETECT_RANGE)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .base_octave    (cfg_r.base_octave),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_scale_index(out_scale_index),
    .out_amp_a      (out_amp_a),
    .out_note_a     (out_note_a),
    .out_amp_b      (out_amp_b),
    .out_note_b     (out_note_b)
  );

  // an accepted transfer always lands in the queue
  a_accept_queued : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !q_empty)
    else $error("accepted transfer missing from queue");

  // saturated scale reaches the result
  a_scale_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_scale_index <= SCALE_MAX))
    else $error("scale index above chromatic");

  // octave saturation keeps both notes within -6..113
  a_note_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_note_a >= -8'sd6) && (out_note_a <= 8'sd113) &&
                   (out_note_b >= -8'sd6) && (out_note_b <= 8'sd113)))
    else $error("note out of range");

endmodule

FILE: rtl/core/ssnq_front.sv
// Front end: takes input transfers, updates the distance store, picks the scale
// and pushes a classified entry into the queue. Depends on ssnq_pkg.
module ssnq_front
  import ssnq_pkg::*;
#(
  parameter int SENSOR_COUNT = 16,
  parameter int DETECT_RANGE = 200
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [ID_W-1:0]   in_sensor_id,
  input  logic [DIST_W-1:0] in_distance,
  output logic              in_stall,
  input  cfg_t              cfg,
  input  logic              q_full,
  output logic              q_push,
  output entry_t            q_entry
);

  localparam logic [DIST_W-1:0] Range = DIST_W'(DETECT_RANGE);

  logic [DIST_W-1:0]  dist_r [SENSOR_COUNT];
  logic               acc;
  logic [DIST_W-1:0]  d_amp_a, d_note_a, d_amp_b, d_note_b, d_det_x, d_det_y;
  logic               det_x, det_y;
  logic [SCALE_W-1:0] sc_raw;

  function automatic logic detects(input logic [DIST_W-1:0] d);
    return (d != '0) && (d < Range);
  endfunction

  function automatic logic [DIST_W-1:0] invert(input logic [DIST_W-1:0] d);
    return (d >= Range) ? '0 : (Range - d);
  endfunction

  assign acc      = in_valid && !q_full;
  assign in_stall = q_full;
  assign q_push   = acc;

  always_ff @(posedge clk) begin
    for (int k = 0; k < SENSOR_COUNT; k++) begin
      if (!rst_n) begin
        dist_r[k] <= Range;
      end else if (acc && (8'(in_sensor_id) == 8'(k))) begin
        dist_r[k] <= in_distance;
      end
    end
  end

  // store contents as seen after this transfer's write
  assign d_amp_a  = (acc && in_sensor_id == ID_W'(SENS_AMP_A))  ? in_distance : dist_r[SENS_AMP_A];
  assign d_note_a = (acc && in_sensor_id == ID_W'(SENS_NOTE_A)) ? in_distance : dist_r[SENS_NOTE_A];
  assign d_amp_b  = (acc && in_sensor_id == ID_W'(SENS_AMP_B))  ? in_distance : dist_r[SENS_AMP_B];
  assign d_note_b = (acc && in_sensor_id == ID_W'(SENS_NOTE_B)) ? in_distance : dist_r[SENS_NOTE_B];
  assign d_det_x  = (acc && in_sensor_id == ID_W'(SENS_DET_X))  ? in_distance : dist_r[SENS_DET_X];
  assign d_det_y  = (acc && in_sensor_id == ID_W'(SENS_DET_Y))  ? in_distance : dist_r[SENS_DET_Y];

  assign det_x = detects(d_det_x);
  assign det_y = detects(d_det_y);

  always_comb begin
    if (det_x && det_y) begin
      sc_raw = cfg.scale_both;
    end else if (det_x || det_y) begin
      sc_raw = cfg.scale_one;
    end else begin
      sc_raw = cfg.scale_none;
    end
  end

  always_comb begin
    q_entry.scale      = (sc_raw > SCALE_MAX) ? SCALE_MAX : sc_raw;
    q_entry.inv_amp_a  = invert(d_amp_a);
    q_entry.inv_note_a = invert(d_note_a);
    q_entry.inv_amp_b  = invert(d_amp_b);
    q_entry.inv_note_b = invert(d_note_b);
  end

endmodule

FILE: rtl/core/ssnq_queue.sv
// Short FIFO of classified entries between front and back ends.
// Depends on ssnq_pkg.
module ssnq_queue
  import ssnq_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t head,
  output logic   full,
  output logic   empty
);

  entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign full   = (cnt_r == QCNT_W'(QDEPTH));
  assign empty  = (cnt_r == '0);
  assign do_pop = pop && !empty;
  assign head   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/ssnq_cdiv.sv
// Three-stage divider by a fixed divisor: reciprocal multiply, back-multiply,
// one-step correction. Depends on ssnq_pkg.
module ssnq_cdiv
  import ssnq_pkg::*;
#(
  parameter int DIVISOR = 400
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  output logic [QUO_W-1:0] quo
);

  localparam int DivBits = $clog2(DIVISOR);
  localparam int Shift   = QUO_W + DivBits;
  localparam int ProdW   = NUM_W + MUL_W;
  localparam longint unsigned RecipFull = (64'd1 << Shift) / 64'(DIVISOR);
  localparam logic [MUL_W-1:0] Recip = MUL_W'(RecipFull);
  localparam logic [NUM_W-1:0] Dvs   = NUM_W'(DIVISOR);

  logic [ProdW-1:0] prod_r;
  logic [NUM_W-1:0] num1_r, num2_r, back_r, rem;
  logic [QUO_W-1:0] est, est_r, quo_r;

  // estimate is the true quotient or one below it
  assign est = QUO_W'(prod_r >> Shift);
  assign rem = num2_r - back_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= ProdW'(num) * ProdW'(Recip);
      num1_r <= num;
      est_r  <= est;
      back_r <= NUM_W'(est) * Dvs;
      num2_r <= num1_r;
      quo_r  <= est_r + QUO_W'(rem >= Dvs);
    end
  end

  assign quo = quo_r;

endmodule

FILE: rtl/core/ssnq_back.sv
// Back end: pops classified entries, forms rounded amplitudes and scale notes in
// four divider lanes and holds the result register. Depends on ssnq_pkg, ssnq_cdiv.
module ssnq_back
  import ssnq_pkg::*;
#(
  parameter int DETECT_RANGE = 200
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [OCT_W-1:0]         base_octave,
  input  logic                     q_empty,
  input  entry_t                   q_head,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [SCALE_W-1:0]       out_scale_index,
  output logic [AMP_W-1:0]         out_amp_a,
  output logic signed [NOTE_W-1:0] out_note_a,
  output logic [AMP_W-1:0]         out_amp_b,
  output logic signed [NOTE_W-1:0] out_note_b
);

  localparam int Divisor = 2 * DETECT_RANGE;
  localparam logic [NUM_W-1:0] Half = NUM_W'(DETECT_RANGE);
  localparam int LANE_AMP_A  = 0;
  localparam int LANE_NOTE_A = 1;
  localparam int LANE_AMP_B  = 2;
  localparam int LANE_NOTE_B = 3;

  logic                 adv;
  logic                 s0_vld_r, d1_vld_r, d2_vld_r, d3_vld_r, out_valid_r;
  logic [SCALE_W-1:0]   s0_sc_r, d1_sc_r, d2_sc_r, d3_sc_r;
  logic [NUM_W-1:0]     num_r [4];
  logic [QUO_W-1:0]     quo [4];
  logic [3:0]           head_len;
  logic [NUM_W-1:0]     note_mul;
  logic [SCALE_W-1:0]   sc_out_r;
  logic [AMP_W-1:0]     amp_a_r, amp_b_r;
  logic [NOTE_W-1:0]    note_a_r, note_b_r, note_a_nxt, note_b_nxt;

  function automatic logic [NOTE_W-1:0] note_of(
    input logic [SCALE_W-1:0] sc,
    input logic [QUO_W-1:0]   q,
    input logic [OCT_W-1:0]   oct
  );
    logic [3:0]        len;
    logic [4:0]        steps, idx, rel, off;
    logic [OCT_W-1:0]  octs;
    len   = SCALE_LEN[sc];
    steps = {len, 1'b0};
    if (q >= QUO_W'(steps)) begin
      idx = steps - 5'd1;
    end else begin
      idx = q[4:0];
    end
    rel = idx - {1'b0, len};
    if (idx < {1'b0, len}) begin
      off = {1'b0, SCALE_TAB[sc][idx[3:0]]};
    end else begin
      off = 5'd12 + {1'b0, SCALE_TAB[sc][rel[3:0]]};
    end
    octs = (oct > OCTAVE_MAX) ? OCTAVE_MAX : oct;
    return NOTE_W'(octs) * SEMIS + NOTE_W'(off) - NOTE_SHIFT;
  endfunction

  // whole pipe moves while the result register is free or being taken
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_empty;

  assign head_len = SCALE_LEN[q_head.scale];
  assign note_mul = NUM_W'({head_len, 2'b00});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r    <= 1'b0;
      d1_vld_r    <= 1'b0;
      d2_vld_r    <= 1'b0;
      d3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r    <= !q_empty;
      d1_vld_r    <= s0_vld_r;
      d2_vld_r    <= d1_vld_r;
      d3_vld_r    <= d2_vld_r;
      out_valid_r <= d3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_sc_r <= q_head.scale;
      d1_sc_r <= s0_sc_r;
      d2_sc_r <= d1_sc_r;
      d3_sc_r <= d2_sc_r;
      num_r[LANE_AMP_A]  <= NUM_W'(q_head.inv_amp_a) * NUM_W'(AMP_NUM_MUL) + Half;
      num_r[LANE_NOTE_A] <= NUM_W'(q_head.inv_note_a) * note_mul + Half;
      num_r[LANE_AMP_B]  <= NUM_W'(q_head.inv_amp_b) * NUM_W'(AMP_NUM_MUL) + Half;
      num_r[LANE_NOTE_B] <= NUM_W'(q_head.inv_note_b) * note_mul + Half;
      sc_out_r <= d3_sc_r;
      amp_a_r  <= quo[LANE_AMP_A][AMP_W-1:0];
      amp_b_r  <= quo[LANE_AMP_B][AMP_W-1:0];
      note_a_r <= note_a_nxt;
      note_b_r <= note_b_nxt;
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    ssnq_cdiv #(
      .DIVISOR(Divisor)
    ) u_div (
      .clk(clk),
      .en (adv),
      .num(num_r[g]),
      .quo(quo[g])
    );
  end

  assign note_a_nxt = note_of(d3_sc_r, quo[LANE_NOTE_A], base_octave);
  assign note_b_nxt = note_of(d3_sc_r, quo[LANE_NOTE_B], base_octave);

  assign out_valid       = out_valid_r;
  assign out_scale_index = sc_out_r;
  assign out_amp_a       = amp_a_r;
  assign out_amp_b       = amp_b_r;
  assign out_note_a      = $signed(note_a_r);
  assign out_note_b      = $signed(note_b_r);

endmodule

FILE: verif/tb_sensor_scale_note_quantizer.sv
`timescale 1ns / 1ps
// Self-checking testbench for sensor_scale_note_quantizer: directed and random readings,
// checked against a behavioural model of the quantiser. Depends on ssnq_pkg and the RTL.
module tb_sensor_scale_note_quantizer;
  import ssnq_pkg::*;

  // Behavioural constants, kept apart from the package so a wrong table in the RTL shows up
  localparam int unsigned DETECT     = 200;
  localparam int unsigned AMP_SPAN   = 65535;
  localparam logic [3:0]  TOP_SCALE  = 4'd10;
  localparam logic [3:0]  TOP_OCTAVE = 4'd8;
  localparam int          ROOT_SHIFT = 6;

  // Sensor roles
  localparam int NOTE_B_SENSOR = 0;
  localparam int AMP_B_SENSOR  = 3;
  localparam int AMP_A_SENSOR  = 4;
  localparam int DET_X_SENSOR  = 5;
  localparam int NOTE_A_SENSOR = 6;
  localparam int DET_Y_SENSOR  = 7;

  localparam int QUIET_LIMIT  = 1000;  // cycles with no transfer before giving up
  localparam int SETTLE_TICKS = 12;    // covers the result path, plus margin
  localparam int PRINT_CAP    = 40;
  localparam int PHASE_ITEMS  = 80;

  localparam bit [3:0] SCALE_DEGREES [11][12] = '{
    '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd1, 4'd3, 4'd5, 4'd6, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd4, 4'd7, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd3, 4'd5, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd3, 4'd5, 4'd6, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11}
  };
  localparam int unsigned SCALE_SIZE [11] = '{7, 7, 7, 7, 7, 7, 7, 5, 5, 6, 12};

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [AMP_W-1:0]   amp_a;
    logic [NOTE_W-1:0]  note_a;
    logic [AMP_W-1:0]   amp_b;
    logic [NOTE_W-1:0]  note_b;
  } tone_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CIDX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]         cfg_wdata;
  logic                     in_valid;
  logic                     in_stall;
  logic [ID_W-1:0]          in_sensor_id;
  logic [DIST_W-1:0]        in_distance;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [SCALE_W-1:0]       out_scale_index;
  logic [AMP_W-1:0]         out_amp_a;
  logic signed [NOTE_W-1:0] out_note_a;
  logic [AMP_W-1:0]         out_amp_b;
  logic signed [NOTE_W-1:0] out_note_b;

  // Model copy of the store and the registers
  logic [DIST_W-1:0] shadow_distances [16];
  logic [CFG_W-1:0]  m_octave, m_scale_both, m_scale_one, m_scale_none;

  tone_t pending_tones [$];
  int    mismatch_count = 0;
  int    quiet_cycles   = 0;
  int    send_gap_pct   = 0;
  int    recv_stall_pct = 0;

  sensor_scale_note_quantizer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sensor_id    (in_sensor_id),
    .in_distance     (in_distance),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_scale_index (out_scale_index),
    .out_amp_a       (out_amp_a),
    .out_note_a      (out_note_a),
    .out_amp_b       (out_amp_b),
    .out_note_b      (out_note_b)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Model of the quantiser
  // ---------------------------------------------------------------------------

  // Clamp to the detect range and invert: near objects give large values
  function automatic int unsigned proximity(input logic [DIST_W-1:0] d);
    if (d >= DETECT) return 0;
    return DETECT - d;
  endfunction

  function automatic logic is_detected(input logic [DIST_W-1:0] d);
    return (d != 0) && (d < DETECT);
  endfunction

  // Fraction of full scale, halves rounded up
  function automatic logic [AMP_W-1:0] amplitude_of(input logic [DIST_W-1:0] d);
    int unsigned num;
    num = 2 * AMP_SPAN * proximity(d) + DETECT;
    return AMP_W'(num / (2 * DETECT));
  endfunction

  // Step across two octaves of the scale, halves up, top step clamped
  function automatic logic [NOTE_W-1:0] note_of(input logic [DIST_W-1:0] d,
                                                input logic [SCALE_W-1:0] sc);
    int unsigned span, steps, step, semis, oct;
    int          midi;
    span  = SCALE_SIZE[sc];
    steps = 2 * span;
    step  = (2 * steps * proximity(d) + DETECT) / (2 * DETECT);
    if (step >= steps) step = steps - 1;
    if (step < span) semis = 32'(SCALE_DEGREES[sc][step]);
    else semis = 12 + 32'(SCALE_DEGREES[sc][step - span]);
    oct  = 32'((m_octave > TOP_OCTAVE) ? TOP_OCTAVE : m_octave);
    midi = int'(oct * 12 + semis) - ROOT_SHIFT;
    return midi[NOTE_W-1:0];
  endfunction

  function automatic tone_t predict_tone();
    tone_t          t;
    logic           hit_x, hit_y;
    logic [SCALE_W-1:0] sc;
    hit_x = is_detected(shadow_distances[DET_X_SENSOR]);
    hit_y = is_detected(shadow_distances[DET_Y_SENSOR]);
    if (hit_x && hit_y) sc = m_scale_both;
    else if (hit_x || hit_y) sc = m_scale_one;
    else sc = m_scale_none;
    if (sc > TOP_SCALE) sc = TOP_SCALE;
    t.scale  = sc;
    t.amp_a  = amplitude_of(shadow_distances[AMP_A_SENSOR]);
    t.note_a = note_of(shadow_distances[NOTE_A_SENSOR], sc);
    t.amp_b  = amplitude_of(shadow_distances[AMP_B_SENSOR]);
    t.note_b = note_of(shadow_distances[NOTE_B_SENSOR], sc);
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Input transfers update the model and queue a tone; result transfers are
  // compared with the oldest queued tone. One block keeps the order fixed.
  always @(posedge clk) begin : tone_scoreboard
    tone_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        shadow_distances[in_sensor_id] = in_distance;
        pending_tones.push_back(predict_tone());
      end
      if (out_valid && !out_stall) begin
        if (pending_tones.size() == 0) begin
          flag_mismatch("result transfer with no tone pending");
        end else begin
          want = pending_tones.pop_front();
          if (out_scale_index !== want.scale)
            flag_mismatch($sformatf("scale_index got %0d want %0d",
                                    out_scale_index, want.scale));
          if (out_amp_a !== want.amp_a)
            flag_mismatch($sformatf("amp_a got %0d want %0d", out_amp_a, want.amp_a));
          if (out_note_a !== want.note_a)
            flag_mismatch($sformatf("note_a got %0d want %0d",
                                    out_note_a, $signed(want.note_a)));
          if (out_amp_b !== want.amp_b)
            flag_mismatch($sformatf("amp_b got %0d want %0d", out_amp_b, want.amp_b));
          if (out_note_b !== want.note_b)
            flag_mismatch($sformatf("note_b got %0d want %0d",
                                    out_note_b, $signed(want.note_b)));
        end
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: count cycles in which neither channel completes a transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("sensor_scale_note_quantizer test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One reading, preceded by a random number of idle cycles with junk payload.
  // Returns at the edge where the transfer happens.
  task automatic send_reading(input logic [ID_W-1:0] id, input logic [DIST_W-1:0] mm);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid     <= 1'b0;
      in_sensor_id <= ID_W'($urandom);
      in_distance  <= DIST_W'($urandom);
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sensor_id <= id;
    in_distance  <= mm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic put_register(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Registers change only once every pending tone has come back; the extra
  // edge lets the scoreboard log the last input transfer first
  task automatic apply_settings(input logic [CFG_W-1:0] octave, both, one, none);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_tones.size() != 0) @(posedge clk);
    put_register(CFG_BASE_OCTAVE, octave);
    put_register(CFG_SCALE_BOTH, both);
    put_register(CFG_SCALE_ONE, one);
    put_register(CFG_SCALE_NONE, none);
    cfg_we       <= 1'b0;
    m_octave     = octave;
    m_scale_both = both;
    m_scale_one  = one;
    m_scale_none = none;
  endtask

  // Mostly the sensors that matter and distances near the detect range
  task automatic send_random_reading();
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] reading;
    int                pick;
    if ($urandom_range(99) < 75) begin
      pick = $urandom_range(5);
      case (pick)
        0:       id = ID_W'(NOTE_B_SENSOR);
        1:       id = ID_W'(AMP_B_SENSOR);
        2:       id = ID_W'(AMP_A_SENSOR);
        3:       id = ID_W'(DET_X_SENSOR);
        4:       id = ID_W'(NOTE_A_SENSOR);
        default: id = ID_W'(DET_Y_SENSOR);
      endcase
    end else begin
      id = ID_W'($urandom_range(15));
    end
    pick = $urandom_range(99);
    if (pick < 55) begin
      reading = DIST_W'($urandom_range(DETECT));
    end else if (pick < 75) begin
      case ($urandom_range(4))
        0:       reading = '0;
        1:       reading = DIST_W'(1);
        2:       reading = DIST_W'(DETECT - 1);
        3:       reading = DIST_W'(DETECT);
        default: reading = DIST_W'(DETECT + 1);
      endcase
    end else begin
      reading = DIST_W'($urandom);
    end
    send_reading(id, reading);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Unused sensors, including the top id, must leave every output at its default
  task automatic test_idle_sensors();
    send_reading(4'd15, 16'hFFFF);
    send_reading(4'd10, 16'h0000);
  endtask

  // Full scale, zero, exact half (rounds up) and beyond range
  task automatic test_amplitude_extremes();
    send_reading(ID_W'(AMP_A_SENSOR), 16'd0);
    send_reading(ID_W'(AMP_A_SENSOR), 16'd100);
    send_reading(ID_W'(AMP_A_SENSOR), 16'd200);
    send_reading(ID_W'(AMP_A_SENSOR), 16'hFFFF);
    send_reading(ID_W'(AMP_B_SENSOR), 16'd1);
    send_reading(ID_W'(AMP_B_SENSOR), 16'd199);
    send_reading(ID_W'(AMP_B_SENSOR), 16'd201);
  endtask

  // Top step clamps to 2L-1; beyond range gives the lowest step
  task automatic test_note_extremes();
    send_reading(ID_W'(NOTE_A_SENSOR), 16'd0);
    send_reading(ID_W'(NOTE_A_SENSOR), 16'd200);
    send_reading(ID_W'(NOTE_A_SENSOR), 16'd43);
    send_reading(ID_W'(NOTE_B_SENSOR), 16'd0);
    send_reading(ID_W'(NOTE_B_SENSOR), 16'hFFFF);
    send_reading(ID_W'(NOTE_B_SENSOR), 16'd57);
  endtask

  // None, one and both detection sensors; 0 and the range itself do not detect
  task automatic test_scale_selection();
    send_reading(ID_W'(DET_X_SENSOR), 16'd100);
    send_reading(ID_W'(DET_Y_SENSOR), 16'd50);
    send_reading(ID_W'(DET_X_SENSOR), 16'd0);
    send_reading(ID_W'(DET_Y_SENSOR), 16'd200);
    send_reading(ID_W'(DET_X_SENSOR), 16'd199);
    send_reading(ID_W'(DET_Y_SENSOR), 16'd1);
  endtask

  // Oversized octave and scale values saturate; lowest and highest notes
  task automatic test_register_saturation();
    apply_settings(4'd15, 4'd15, 4'd15, 4'd15);
    send_reading(ID_W'(NOTE_A_SENSOR), 16'd0);
    send_reading(ID_W'(DET_X_SENSOR), 16'd500);
    apply_settings(4'd0, 4'd10, 4'd10, 4'd10);
    send_reading(ID_W'(NOTE_A_SENSOR), 16'd300);
    send_reading(ID_W'(DET_Y_SENSOR), 16'd0);
  endtask

  task automatic test_random_readings();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       apply_settings(4'd8, 4'd10, 4'd0, 4'd7);
        1:       apply_settings(4'd15, 4'd12, 4'd15, 4'd11);
        3:       apply_settings(4'd0, 4'd0, 4'd10, 4'd15);
        default: apply_settings(CFG_W'($urandom), CFG_W'($urandom),
                                CFG_W'($urandom), CFG_W'($urandom));
      endcase
      // sender-light/receiver-heavy, then the reverse, then flat out
      if (phase < 3) begin
        send_gap_pct   = 6;
        recv_stall_pct = 72;
      end else if (phase < 6) begin
        send_gap_pct   = 72;
        recv_stall_pct = 6;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      repeat (PHASE_ITEMS) send_random_reading();
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_BASE_OCTAVE;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    in_sensor_id <= '0;
    in_distance  <= '0;
    foreach (shadow_distances[k]) shadow_distances[k] = DIST_W'(DETECT);
    m_octave     = RST_BASE_OCTAVE;
    m_scale_both = RST_SCALE_BOTH;
    m_scale_one  = RST_SCALE_ONE;
    m_scale_none = RST_SCALE_NONE;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_gap_pct   = 6;
    recv_stall_pct = 72;
    test_idle_sensors();
    test_amplitude_extremes();
    test_note_extremes();
    test_scale_selection();
    test_register_saturation();
    test_random_readings();

    // Drain, then give the pipe time to show any stray transfer
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_tones.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("sensor_scale_note_quantizer test passed");
    end else begin
      $display("sensor_scale_note_quantizer test failed");
    end
    $finish;
  end

endmodule

FILE: sensor_scale_note_quantizer.f
rtl/core/ssnq_pkg.sv
rtl/core/ssnq_front.sv
rtl/core/ssnq_queue.sv
rtl/core/ssnq_cdiv.sv
rtl/core/ssnq_back.sv
rtl/core/sensor_scale_note_quantizer.sv
verif/tb_sensor_scale_note_quantizer.sv
